// ----- hdl/sdhfp_pkg.sv -----
// Shared constants for the signed decimal and hex field parser.
package sdhfp_pkg;

  localparam int unsigned ValueBits  = 32;
  localparam int unsigned StatusBits = 2;

  localparam logic [StatusBits-1:0] StatusOk    = 2'd0;
  localparam logic [StatusBits-1:0] StatusBad   = 2'd1;
  localparam logic [StatusBits-1:0] StatusEmpty = 2'd2;

  localparam logic [7:0] CharNul    = 8'h00;
  localparam logic [7:0] CharTab    = 8'h09;
  localparam logic [7:0] CharCr     = 8'h0D;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharComma  = 8'h2C;
  localparam logic [7:0] CharMinus  = 8'h2D;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;
  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperF = 8'h46;
  localparam logic [7:0] CharUpperX = 8'h58;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharLowerX = 8'h78;
  localparam logic [7:0] CharLowerZ = 8'h7A;
  localparam logic [7:0] CaseOffset = 8'h20;

endpackage

// ----- hdl/signed_dec_hex_field_parser.sv -----
// Streaming parser for comma-separated signed decimal and hexadecimal fields.
// The block takes one character item per cycle unless in_stall_o is high, and gives at most
// one result item per character. A character passes through the input register and then
// the result register. The parse state advances by a single multiply-by-ten or
// shift-by-four and add between those two registers, so characters may follow
// one another without gaps. A field closes on a comma, on a zero byte or on a bad
// character; after a bad character all items up to and including the next zero byte are
// dropped. The accumulator is VALUE_WIDTH bits wide and wraps; the value output carries
// the low 32 bits of the signed value.
module signed_dec_hex_field_parser #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         char_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] value_o,
  output logic [1:0]         status_o,
  output logic               end_of_string_o
);
  import sdhfp_pkg::*;

  typedef enum logic [2:0] {
    PhStringStart,
    PhLeadSpace,
    PhAfterComma,
    PhAfterSign,
    PhFirstZero,
    PhDigits,
    PhTrailSpace,
    PhSkip
  } phase_e;

  phase_e                  phase_q, phase_d;
  logic                    negative_q, negative_d;
  logic                    hex_mode_q, hex_mode_d;
  logic [VALUE_WIDTH-1:0]  acc_q, acc_d;

  logic                    in_valid_q;
  logic [7:0]              char_q;

  logic                    out_valid_q;
  logic [ValueBits-1:0]    value_q;
  logic [StatusBits-1:0]   status_q;
  logic                    eos_q;

  logic                    is_space;
  logic                    is_dec;
  logic                    is_hex_letter;
  logic [7:0]              upper_char;
  logic                    digit_ok;
  logic [3:0]              digit_val;
  logic [VALUE_WIDTH-1:0]  acc_next;
  logic [VALUE_WIDTH-1:0]  signed_val;

  logic                    emit;
  logic                    go_digits;
  logic                    use_signed;
  logic [StatusBits-1:0]   res_status;
  logic                    res_eos;
  logic [VALUE_WIDTH-1:0]  res_val;

  logic                    out_free;
  logic                    advance;

  always_comb begin
    is_space      = (char_q == CharSpace) || (char_q inside {[CharTab:CharCr]});
    is_dec        = char_q inside {[CharZero:CharNine]};
    upper_char    = (char_q inside {[CharLowerA:CharLowerZ]}) ? char_q - CaseOffset : char_q;
    is_hex_letter = hex_mode_q && (upper_char inside {[CharUpperA:CharUpperF]});
    digit_ok      = is_dec || is_hex_letter;
    digit_val     = is_dec ? char_q[3:0] : 4'(upper_char - CharUpperA + 8'd10);
    if (hex_mode_q) begin
      acc_next = {acc_q[VALUE_WIDTH-5:0], digit_val};
    end else begin
      acc_next = (acc_q << 3) + (acc_q << 1) + VALUE_WIDTH'(digit_val);
    end
    signed_val = negative_q ? (~acc_q + VALUE_WIDTH'(1)) : acc_q;
  end

  always_comb begin
    phase_d    = phase_q;
    negative_d = negative_q;
    hex_mode_d = hex_mode_q;
    acc_d      = acc_q;
    emit       = 1'b0;
    go_digits  = 1'b0;
    use_signed = 1'b0;
    res_status = StatusOk;
    res_eos    = 1'b0;

    case (phase_q)
      PhStringStart, PhLeadSpace, PhAfterComma: begin
        if (char_q == CharNul) begin
          emit       = 1'b1;
          res_status = (phase_q == PhLeadSpace) ? StatusBad : StatusEmpty;
          res_eos    = 1'b1;
          phase_d    = PhStringStart;
        end else if (is_space) begin
          if (phase_q != PhAfterComma) begin
            phase_d = PhLeadSpace;
          end
        end else if (char_q == CharMinus) begin
          negative_d = 1'b1;
          phase_d    = PhAfterSign;
        end else if (char_q == CharZero) begin
          phase_d = PhFirstZero;
        end else begin
          go_digits = 1'b1;
        end
      end
      PhAfterSign: begin
        if (char_q == CharNul) begin
          emit       = 1'b1;
          res_status = StatusBad;
          res_eos    = 1'b1;
          phase_d    = PhStringStart;
        end else if (char_q == CharZero) begin
          phase_d = PhFirstZero;
        end else begin
          go_digits = 1'b1;
        end
      end
      PhFirstZero: begin
        if (char_q == CharLowerX || char_q == CharUpperX) begin
          hex_mode_d = 1'b1;
          phase_d    = PhDigits;
        end else begin
          go_digits = 1'b1;
        end
      end
      PhDigits: begin
        go_digits = 1'b1;
      end
      PhTrailSpace: begin
        go_digits = 1'b0;
      end
      default: begin
        if (char_q == CharNul) begin
          phase_d = PhStringStart;
        end
      end
    endcase

    // Digits extend the number; anything else is handled as the end of the number.
    if ((go_digits && !digit_ok) || phase_q == PhTrailSpace) begin
      if (is_space) begin
        phase_d = PhTrailSpace;
      end else if (char_q == CharComma) begin
        emit       = 1'b1;
        use_signed = 1'b1;
        res_status = StatusOk;
        res_eos    = 1'b0;
        phase_d    = PhAfterComma;
      end else if (char_q == CharNul) begin
        emit       = 1'b1;
        use_signed = 1'b1;
        res_status = StatusOk;
        res_eos    = 1'b1;
        phase_d    = PhStringStart;
      end else begin
        emit       = 1'b1;
        use_signed = 1'b1;
        res_status = StatusBad;
        res_eos    = 1'b1;
        phase_d    = PhSkip;
      end
    end else if (go_digits) begin
      phase_d = PhDigits;
      acc_d   = acc_next;
    end

    res_val = use_signed ? signed_val : '0;

    if (emit) begin
      negative_d = 1'b0;
      hex_mode_d = 1'b0;
      acc_d      = '0;
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && (!emit || out_free);
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PhStringStart;
      negative_q  <= 1'b0;
      hex_mode_q  <= 1'b0;
      acc_q       <= '0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= advance && emit;
      end
      if (advance) begin
        phase_q    <= phase_d;
        negative_q <= negative_d;
        hex_mode_q <= hex_mode_d;
        acc_q      <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      char_q <= char_byte_i;
    end
    if (advance && emit) begin
      value_q  <= ValueBits'(res_val);
      status_q <= res_status;
      eos_q    <= res_eos;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign value_o         = signed'(value_q);
  assign status_o        = status_q;
  assign end_of_string_o = eos_q;

endmodule
